>>> rtl/iss_pkg.sv
// Shared types and constants of the integer set store.
package iss_pkg;

  localparam int VALUE_W          = 32;
  localparam int COUNT_W          = 5;
  localparam int REQ_W            = 2;
  localparam int DEFAULT_CAPACITY = 16;
  localparam int QUEUE_DEPTH      = 2;

  // Request codes as they arrive on the request channel
  localparam logic [REQ_W-1:0] REQ_ADD    = 2'd0;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_QUERY  = 2'd2;
  localparam logic [REQ_W-1:0] REQ_LIST   = 2'd3;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_QUERY  = 2'd2,
    OP_LIST   = 2'd3
  } op_e;

  typedef struct packed {
    op_e                        op;
    logic signed [VALUE_W-1:0]  value;
  } req_t;

endpackage

>>> rtl/iss_if.sv
// Request and response channel interfaces of the integer set store.
interface iss_req_if;
  import iss_pkg::*;
  logic                       valid;
  logic                       ready;
  logic [REQ_W-1:0]           req_type;
  logic signed [VALUE_W-1:0]  value;

  modport source (output valid, req_type, value, input ready);
  modport sink   (input valid, req_type, value, output ready);
endinterface

interface iss_rsp_if;
  import iss_pkg::*;
  logic                       valid;
  logic                       ready;
  logic                       found;
  logic [COUNT_W-1:0]         count;
  logic signed [VALUE_W-1:0]  element;
  logic                       element_valid;
  logic                       rejected_full;
  logic                       last;

  modport source (output valid, found, count, element, element_valid, rejected_full, last,
                  input ready);
  modport sink   (input valid, found, count, element, element_valid, rejected_full, last,
                  output ready);
endinterface

>>> rtl/integer_set_store_core.sv
// Top level of the integer set store: request queue front end and set engine.
// In the set engine, add, remove and query first match the value against all cells in
// parallel, then update the cells and load the response register.
// A list is taken like the others, then streams one stored element per response, in insertion order;
// an empty list is answered like a query. An accepted request passes through the queue and
// the match registers before it loads the response register, which waits on a held response.
// Reset clears the occupancy, queue and response valid; cell contents are left undefined.
module integer_set_store_core #(
  parameter int CAPACITY = iss_pkg::DEFAULT_CAPACITY
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  iss_req_if.sink   req_i,
  iss_rsp_if.source rsp_o
);
  import iss_pkg::*;

  logic q_valid;
  logic q_pop;
  req_t q_item;

  iss_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req_i),
    .q_valid_o (q_valid),
    .q_item_o  (q_item),
    .q_pop_i   (q_pop)
  );

  iss_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_item_i  (q_item),
    .q_pop_o   (q_pop),
    .rsp_o     (rsp_o)
  );

endmodule

>>> rtl/iss_front.sv
// Request front end: decodes the request code and buffers transactions in a short queue.
module iss_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  iss_req_if.sink       req_i,
  output logic          q_valid_o,
  output iss_pkg::req_t q_item_o,
  input  logic          q_pop_i
);
  import iss_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  req_t          mem_q [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          push, pop;
  req_t          item;

  always_comb begin
    item.value = req_i.value;
    case (req_i.req_type)
      REQ_ADD:    item.op = OP_ADD;
      REQ_REMOVE: item.op = OP_REMOVE;
      REQ_QUERY:  item.op = OP_QUERY;
      REQ_LIST:   item.op = OP_LIST;
      default:    item.op = OP_LIST;
    endcase
  end

  assign req_i.ready = (cnt_q != CW'(QUEUE_DEPTH));
  assign push        = req_i.valid && req_i.ready;
  assign pop         = q_pop_i && (cnt_q != '0);
  assign q_valid_o   = (cnt_q != '0);
  assign q_item_o    = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= item;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(QUEUE_DEPTH))
    else $error("queue count above depth");

  a_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == CW'(QUEUE_DEPTH)) && !pop |=> cnt_q == CW'(QUEUE_DEPTH))
    else $error("full queue lost an entry without a pop");

  a_pop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && !push |=> cnt_q == $past(cnt_q) - CW'(1))
    else $error("pop did not reduce queue count");

endmodule

>>> rtl/iss_back.sv
// Set engine: register cells with parallel match, compaction on remove, list streaming.
module iss_back #(
  parameter int CAPACITY = iss_pkg::DEFAULT_CAPACITY
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_valid_i,
  input  iss_pkg::req_t q_item_i,
  output logic          q_pop_o,
  iss_rsp_if.source     rsp_o
);
  import iss_pkg::*;

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int OW = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_APPLY = 3'b010,
    S_LIST  = 3'b100
  } state_e;

  state_e                     state_q, state_d;
  logic signed [VALUE_W-1:0]  entries_q [CAPACITY];
  logic [OW-1:0]              occ_q, occ_d;
  logic [CAPACITY-1:0]        hit_q, hit_d;
  op_e                        op_q;
  logic signed [VALUE_W-1:0]  val_q;
  logic [IW-1:0]              idx_q;
  logic [IW-1:0]              pos;
  logic                       found, full, out_free;
  logic                       take, apply_fire, list_fire, list_last;

  logic                       out_valid_q;
  logic                       found_q, elem_valid_q, rej_q, last_q;
  logic [COUNT_W-1:0]         count_q;
  logic signed [VALUE_W-1:0]  elem_q;

  assign out_free   = !out_valid_q || rsp_o.ready;
  assign take       = (state_q == S_IDLE) && q_valid_i;
  assign q_pop_o    = take;
  assign apply_fire = (state_q == S_APPLY) && out_free;
  assign list_fire  = (state_q == S_LIST) && out_free;
  assign found      = |hit_q;
  assign full       = (occ_q == OW'(CAPACITY));
  assign list_last  = ((OW'(idx_q) + OW'(1)) == occ_q);

  // Match the queue head against every occupied cell
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      hit_d[i] = (entries_q[i] == q_item_i.value) && (OW'(i) < occ_q);
    end
  end

  // Values are distinct, so the hit vector is one-hot or zero and ORing indexes encodes it
  always_comb begin
    pos = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (hit_q[i]) pos = pos | IW'(i);
    end
  end

  always_comb begin
    occ_d = occ_q;
    if (apply_fire) begin
      case (op_q)
        OP_ADD:    if (!found && !full) occ_d = occ_q + OW'(1);
        OP_REMOVE: if (found) occ_d = occ_q - OW'(1);
        default:   occ_d = occ_q;
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (q_valid_i) begin
          state_d = ((q_item_i.op == OP_LIST) && (occ_q != '0)) ? S_LIST : S_APPLY;
        end
      end
      S_APPLY: if (out_free) state_d = S_IDLE;
      S_LIST:  if (out_free && list_last) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      occ_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      occ_q   <= occ_d;
      if (apply_fire || list_fire) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      op_q  <= q_item_i.op;
      val_q <= q_item_i.value;
      hit_q <= hit_d;
      idx_q <= '0;
    end else if (list_fire) begin
      idx_q <= idx_q + IW'(1);
    end
  end

  // Append into the first free cell, or shift the tail down over the removed one
  always_ff @(posedge clk_i) begin
    if (apply_fire && (op_q == OP_ADD) && !found && !full) begin
      for (int i = 0; i < CAPACITY; i++) begin
        if (OW'(i) == occ_q) entries_q[i] <= val_q;
      end
    end else if (apply_fire && (op_q == OP_REMOVE) && found) begin
      for (int i = 0; i + 1 < CAPACITY; i++) begin
        if (IW'(i) >= pos) entries_q[i] <= entries_q[i + 1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (apply_fire) begin
      found_q      <= (op_q == OP_LIST) ? 1'b0 : found;
      count_q      <= COUNT_W'(occ_d);
      elem_q       <= '0;
      elem_valid_q <= 1'b0;
      rej_q        <= (op_q == OP_ADD) && !found && full;
      last_q       <= 1'b1;
    end else if (list_fire) begin
      found_q      <= 1'b0;
      count_q      <= COUNT_W'(occ_q);
      elem_q       <= entries_q[idx_q];
      elem_valid_q <= 1'b1;
      rej_q        <= 1'b0;
      last_q       <= list_last;
    end
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.found         = found_q;
  assign rsp_o.count         = count_q;
  assign rsp_o.element       = elem_q;
  assign rsp_o.element_valid = elem_valid_q;
  assign rsp_o.rejected_full = rej_q;
  assign rsp_o.last          = last_q;

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= OW'(CAPACITY))
    else $error("occupancy above capacity");

  a_hit_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_APPLY) |-> $onehot0(hit_q))
    else $error("value matched in more than one cell");

  a_reject_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && rej_q |-> occ_q == OW'(CAPACITY))
    else $error("add rejected while room remained");

  a_remove_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    apply_fire && (op_q == OP_REMOVE) && found |=> occ_q == $past(occ_q) - OW'(1))
    else $error("remove of a present value did not shrink the set");

  a_list_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LIST) |-> OW'(idx_q) < occ_q)
    else $error("list index past occupancy");

endmodule
